/* src/ffhts_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helpers for the fixed frame header/tail sync unit
// no dependencies

package ffhts_pkg;

    localparam int FRAME_BYTES_DEFAULT = 30;
    localparam int HEADER_BYTES        = 4;
    localparam int CFG_W               = 16;
    localparam int BYTE_W              = 8;

    localparam logic [BYTE_W-1:0] HDR0  = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR1  = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR2  = 8'h03;
    localparam logic [BYTE_W-1:0] HDR3  = 8'h00;
    localparam logic [BYTE_W-1:0] TAIL0 = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL1 = 8'hCC;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [CFG_W-1:0] IDLE_MAX      = 16'hFFFF;

    // kind codes carried in tuser
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_good;
        logic out_valid;
        logic out_taken;
        logic out_last;
    } dp_status_t;

    // expected header byte at a given position
    function automatic logic [BYTE_W-1:0] header_byte(input logic [1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            2'd0:    b = HDR0;
            2'd1:    b = HDR1;
            2'd2:    b = HDR2;
            default: b = HDR3;
        endcase
        return b;
    endfunction

endpackage

/* src/fixed_frame_header_tail_sync_unit.sv */
`timescale 1ns / 1ps
// top level of the fixed frame header/tail sync unit
// depends on ffhts_pkg, ffhts_ctrl, ffhts_datapath (and through it ffhts_ram)

// Hunts a byte stream for the header AA FF 03 00, collects FRAME_BYTES bytes
// (header included) and, when the last two are 55 CC, sends the whole frame out
// on the m_ side with m_tlast on the final byte; a frame with a bad tail is
// dropped silently. Tick requests (s_tuser = 1) advance an idle counter that
// any stored byte clears; once it exceeds the timeout register a partial frame
// is thrown away. Byte and tick requests are taken only while no frame is
// draining. The byte that completes a good frame hands over to the drain
// sequencer, which reads the frame store one address at a time (registered
// ram read, then the output register) and waits on the sink for each byte;
// no request is accepted until the last byte has been taken.
// The timeout register may be written at any time through cfg_valid/cfg_data.

module fixed_frame_header_tail_sync_unit #(
    parameter int FRAME_BYTES = ffhts_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffhts_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] kind: 0 byte, 1 tick
    // validated frame bytes
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffhts_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] frame_byte
    output logic                           m_tlast,   // last_byte
    // stall timeout register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffhts_pkg::CFG_W-1:0]    cfg_data   // [15:0] stall_timeout_ticks
);
    import ffhts_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register is always writable
    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    ffhts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    ffhts_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

endmodule

/* src/ffhts_ram.sv */
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module ffhts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ffhts_datapath.sv */
`timescale 1ns / 1ps
// datapath: fill position, idle tick counter, timeout register, frame store, output register
// depends on ffhts_pkg and ffhts_ram

module ffhts_datapath #(
    parameter int FRAME_BYTES = ffhts_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ffhts_pkg::ctrl_cmd_t                cmd,
    output ffhts_pkg::dp_status_t               status,
    input  logic                                s_tvalid,
    input  logic [ffhts_pkg::BYTE_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ffhts_pkg::BYTE_W-1:0]        m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    input  logic [ffhts_pkg::CFG_W-1:0]         cfg_data
);
    import ffhts_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] POS_LAST = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] POS_HDR  = AW'(HEADER_BYTES);

    logic [AW-1:0]     fill_reg, fill_next;
    logic [CFG_W-1:0]  idle_reg, idle_next;
    logic [CFG_W-1:0]  timeout_reg;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              in_fire;
    logic              hdr_ok;
    logic              store_we;
    logic              frame_good;
    logic [CFG_W-1:0]  idle_inc;
    logic [BYTE_W-1:0] ram_q;

    assign in_fire = s_tvalid && cmd.in_ready;
    assign hdr_ok  = (fill_reg >= POS_HDR) || (s_tdata == header_byte(fill_reg[1:0]));
    assign idle_inc = (idle_reg != IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;

    always_comb begin
        fill_next  = fill_reg;
        idle_next  = idle_reg;
        prev_next  = prev_reg;
        store_we   = 1'b0;
        frame_good = 1'b0;
        if (in_fire) begin
            if (s_tuser == KIND_TICK) begin
                idle_next = idle_inc;
                if (fill_reg != '0 && idle_inc > timeout_reg) begin
                    fill_next = '0;
                end
            end else if (!hdr_ok) begin
                fill_next = '0;
            end else begin
                store_we  = 1'b1;
                idle_next = '0;
                prev_next = s_tdata;
                if (fill_reg == POS_LAST) begin
                    fill_next  = '0;
                    frame_good = (prev_reg == TAIL0) && (s_tdata == TAIL1);
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    // drain side: read address always follows rd_ptr
    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            rd_ptr_next    = (rd_ptr_reg == POS_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            idle_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            idle_reg      <= idle_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        if (cmd.load_out) begin
            out_data_reg <= ram_q;
            out_last_reg <= (rd_ptr_reg == POS_LAST);
        end
    end

    ffhts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (fill_reg),
        .wdata (s_tdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.frame_good = frame_good;
    assign status.out_valid  = out_valid_reg;
    assign status.out_taken  = out_valid_reg && m_tready;
    assign status.out_last   = out_last_reg;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= POS_LAST)
        else $error("fill position beyond frame");

    a_good_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_good |=> (fill_reg == '0 && rd_ptr_reg == '0 && idle_reg == '0))
        else $error("frame completion did not restart fill");

endmodule

/* src/ffhts_ctrl.sv */
`timescale 1ns / 1ps
// controller: accepts items until a good frame completes, then drains it byte by byte
// depends on ffhts_pkg

module ffhts_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ffhts_pkg::dp_status_t  status,
    output ffhts_pkg::ctrl_cmd_t   cmd
);
    import ffhts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (status.frame_good) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_out = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD: begin
                if (status.out_taken) begin
                    state_next = status.out_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_good_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        status.frame_good |=> state_reg == ST_LOAD)
        else $error("good frame did not start drain");

    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        status.out_valid |-> !cmd.in_ready)
        else $error("input accepted while result pending");

    a_load_gives_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> status.out_valid)
        else $error("load did not present a result");

endmodule
